>>> hdl/bf_pkg.sv
// Shared constants, types and codes for the Brainfuck machine core.
package bf_pkg;

	localparam int TAPE_CELLS  = 32768;
	localparam int CODE_DEPTH  = 4096;
	localparam int INPUT_DEPTH = 1024;

	localparam int TA_W  = $clog2(TAPE_CELLS);
	localparam int CA_W  = $clog2(CODE_DEPTH);
	localparam int PC_W  = $clog2(CODE_DEPTH + 1);
	localparam int IA_W  = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
	localparam int IP_W  = $clog2(INPUT_DEPTH + 1);
	localparam int DEP_W = $clog2(CODE_DEPTH + 2);

	localparam logic [7:0] CH_RIGHT = 8'h3E;
	localparam logic [7:0] CH_LEFT  = 8'h3C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;

	typedef enum logic [1:0] {
		ACT_CODE  = 2'd0,
		ACT_INPUT = 2'd1,
		ACT_EXEC  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_END       = 2'd1,
		ST_UNMATCHED = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] byte_in;
	} item_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		status_t    status;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_EXEC,
		S_SCAN,
		S_CLEAR
	} ctrl_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LATCH,
		OP_DECODE,
		OP_EXEC,
		OP_SCAN,
		OP_CLEAR
	} dp_op_t;

	typedef struct packed {
		logic run;
		logic clr;
		logic scan;
		logic scan_more;
		logic clr_last;
	} dp_stat_t;

endpackage

>>> hdl/bf_machine_core.sv
// Top level of the Brainfuck machine core: controller plus datapath.
//
//  channel  | ports               | transfer when
//  ---------+---------------------+---------------------------
//  item     | start, busy, item   | start high and busy low
//  result   | done, result        | done high (one cycle)
//
// Load and clear items pass through latch and decode, plain instructions through
// latch, decode and execute; a bracket also scans the code toward its partner
// (one code memory read per cycle). done is registered and rises in the cycle
// after the item's last step. Reset and each clear start a tape zeroing pass over
// all TAPE_CELLS cells (one tape write per cycle); busy stays high during it.
// The receiver cannot stall: done is a one-cycle strobe.
module bf_machine_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  bf_pkg::item_t   item,
	output logic            busy,
	output logic            done,
	output bf_pkg::result_t result
);
	import bf_pkg::*;

	dp_op_t   op;
	dp_stat_t stat;

	bf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.op     (op)
	);

	bf_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.item   (item),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

endmodule

>>> hdl/bf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/bf_ctrl.sv
// Controller state machine: sequences decode, execute, bracket scan and tape clear.
module bf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bf_pkg::dp_stat_t stat,
	output logic             busy,
	output bf_pkg::dp_op_t   op
);
	import bf_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		busy    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					op      = OP_LATCH;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				op = OP_DECODE;
				if (stat.run) begin
					state_d = S_EXEC;
				end else if (stat.clr) begin
					state_d = S_CLEAR;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_EXEC: begin
				op      = OP_EXEC;
				state_d = stat.scan ? S_SCAN : S_IDLE;
			end
			S_SCAN: begin
				op = OP_SCAN;
				if (!stat.scan_more) begin
					state_d = S_IDLE;
				end
			end
			S_CLEAR: begin
				op = OP_CLEAR;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/bf_dp.sv
// Datapath: machine registers, code/input/tape memories and result register.
module bf_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  bf_pkg::dp_op_t   op,
	input  bf_pkg::item_t    item,
	output bf_pkg::dp_stat_t stat,
	output logic             done,
	output bf_pkg::result_t  result
);
	import bf_pkg::*;

	item_t            item_q, item_d;
	logic [PC_W-1:0]  code_len_q, code_len_d;
	logic [IP_W-1:0]  in_len_q, in_len_d;
	logic [IP_W-1:0]  in_pos_q, in_pos_d;
	logic [TA_W-1:0]  dp_q, dp_d;
	logic [PC_W-1:0]  pc_q, pc_d;
	logic             err_q, err_d;
	logic [PC_W-1:0]  k_q, k_d;
	logic [DEP_W-1:0] depth_q, depth_d;
	logic             fwd_q, fwd_d;
	logic [7:0]       cell_q, cell_d;
	logic [TA_W-1:0]  clr_q, clr_d;
	logic             done_q;
	result_t          res_q, res_d;
	logic             fin;

	logic            code_we;
	logic [CA_W-1:0] code_waddr, code_raddr;
	logic [7:0]      code_rdata;
	logic            in_we;
	logic [IA_W-1:0] in_waddr, in_raddr;
	logic [7:0]      in_rdata;
	logic            tape_we;
	logic [TA_W-1:0] tape_waddr, tape_raddr;
	logic [7:0]      tape_wdata, tape_rdata;

	logic             code_full, in_full, at_end, in_avail, is_bracket;
	logic [PC_W-1:0]  cur_k, k_next;
	logic             fwd_sel, k_fail, hit, take;
	logic [DEP_W-1:0] depth_nx;
	logic [TA_W-1:0]  dp_inc, dp_dec;

	bf_ram #(.WIDTH(8), .DEPTH(CODE_DEPTH)) u_code_ram (
		.clk(clk), .we(code_we), .waddr(code_waddr), .wdata(item_q.byte_in),
		.raddr(code_raddr), .rdata(code_rdata)
	);

	bf_ram #(.WIDTH(8), .DEPTH(INPUT_DEPTH)) u_input_ram (
		.clk(clk), .we(in_we), .waddr(in_waddr), .wdata(item_q.byte_in),
		.raddr(in_raddr), .rdata(in_rdata)
	);

	bf_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape_ram (
		.clk(clk), .we(tape_we), .waddr(tape_waddr), .wdata(tape_wdata),
		.raddr(tape_raddr), .rdata(tape_rdata)
	);

	assign code_full  = (code_len_q == PC_W'(CODE_DEPTH));
	assign in_full    = (in_len_q == IP_W'(INPUT_DEPTH));
	assign at_end     = (pc_q >= code_len_q);
	assign in_avail   = (in_pos_q < in_len_q);
	assign is_bracket = (code_rdata == CH_OPEN) || (code_rdata == CH_CLOSE);

	// bracket scan position: pc when starting, scan pointer afterwards
	assign cur_k   = (op == OP_SCAN) ? k_q : pc_q;
	assign fwd_sel = (op == OP_SCAN) ? fwd_q : (code_rdata == CH_OPEN);
	assign k_fail  = fwd_sel ? ((PC_W+1)'(cur_k) + (PC_W+1)'(1) >= (PC_W+1)'(code_len_q))
	                         : (cur_k == '0);
	assign k_next  = fwd_sel ? PC_W'(cur_k + 1'b1) : PC_W'(cur_k - 1'b1);

	always_comb begin
		depth_nx = depth_q;
		if (code_rdata == CH_OPEN) begin
			depth_nx = fwd_q ? DEP_W'(depth_q + 1'b1) : DEP_W'(depth_q - 1'b1);
		end else if (code_rdata == CH_CLOSE) begin
			depth_nx = fwd_q ? DEP_W'(depth_q - 1'b1) : DEP_W'(depth_q + 1'b1);
		end
	end

	assign hit  = (depth_nx == '0);
	assign take = fwd_q ? (cell_q == 8'd0) : (cell_q != 8'd0);

	assign dp_inc = ((TA_W+1)'(dp_q) + (TA_W+1)'(1) >= (TA_W+1)'(TAPE_CELLS))
	              ? '0 : TA_W'(dp_q + 1'b1);
	assign dp_dec = (dp_q == '0) ? TA_W'(TAPE_CELLS - 1) : TA_W'(dp_q - 1'b1);

	always_comb begin
		stat.run       = (op == OP_DECODE) && (item_q.action == ACT_EXEC) && !err_q && !at_end;
		stat.clr       = (op == OP_DECODE) && (item_q.action == ACT_CLEAR);
		stat.scan      = (op == OP_EXEC) && is_bracket && !k_fail;
		stat.scan_more = (op == OP_SCAN) && !hit && !k_fail;
		stat.clr_last  = (clr_q == TA_W'(TAPE_CELLS - 1));
	end

	always_comb begin
		item_d     = item_q;
		code_len_d = code_len_q;
		in_len_d   = in_len_q;
		in_pos_d   = in_pos_q;
		dp_d       = dp_q;
		pc_d       = pc_q;
		err_d      = err_q;
		k_d        = k_q;
		depth_d    = depth_q;
		fwd_d      = fwd_q;
		cell_d     = cell_q;
		clr_d      = clr_q;
		fin        = 1'b0;
		res_d      = '{out_valid: 1'b0, out_byte: 8'd0, status: ST_OK};

		code_we    = 1'b0;
		code_waddr = code_len_q[CA_W-1:0];
		code_raddr = pc_q[CA_W-1:0];
		in_we      = 1'b0;
		in_waddr   = in_len_q[IA_W-1:0];
		in_raddr   = in_pos_q[IA_W-1:0];
		tape_we    = 1'b0;
		tape_waddr = dp_q;
		tape_raddr = dp_q;
		tape_wdata = 8'd0;

		unique case (op)
			OP_LATCH: begin
				item_d = item;
			end
			OP_DECODE: begin
				unique case (item_q.action)
					ACT_CODE: begin
						fin = 1'b1;
						if (code_full) begin
							res_d.status = ST_FULL;
						end else begin
							code_we    = 1'b1;
							code_len_d = PC_W'(code_len_q + 1'b1);
						end
					end
					ACT_INPUT: begin
						fin = 1'b1;
						if (in_full) begin
							res_d.status = ST_FULL;
						end else begin
							in_we    = 1'b1;
							in_len_d = IP_W'(in_len_q + 1'b1);
						end
					end
					ACT_EXEC: begin
						if (err_q) begin
							fin          = 1'b1;
							res_d.status = ST_UNMATCHED;
						end else if (at_end) begin
							fin          = 1'b1;
							res_d.status = ST_END;
						end
					end
					ACT_CLEAR: begin
						fin        = 1'b1;
						code_len_d = '0;
						in_len_d   = '0;
						in_pos_d   = '0;
						dp_d       = '0;
						pc_d       = '0;
						err_d      = 1'b0;
						clr_d      = '0;
					end
					default: begin
					end
				endcase
			end
			OP_EXEC: begin
				if (is_bracket) begin
					cell_d = tape_rdata;
					fwd_d  = (code_rdata == CH_OPEN);
					if (k_fail) begin
						fin          = 1'b1;
						err_d        = 1'b1;
						res_d.status = ST_UNMATCHED;
					end else begin
						k_d        = k_next;
						depth_d    = DEP_W'(1);
						code_raddr = k_next[CA_W-1:0];
					end
				end else begin
					fin  = 1'b1;
					pc_d = PC_W'(pc_q + 1'b1);
					unique case (code_rdata)
						CH_RIGHT: dp_d = dp_inc;
						CH_LEFT:  dp_d = dp_dec;
						CH_PLUS: begin
							tape_we    = 1'b1;
							tape_wdata = 8'(tape_rdata + 8'd1);
						end
						CH_MINUS: begin
							tape_we    = 1'b1;
							tape_wdata = 8'(tape_rdata - 8'd1);
						end
						CH_DOT: begin
							res_d.out_valid = 1'b1;
							res_d.out_byte  = tape_rdata;
						end
						CH_COMMA: begin
							tape_we = 1'b1;
							if (in_avail) begin
								tape_wdata = in_rdata;
								in_pos_d   = IP_W'(in_pos_q + 1'b1);
							end
						end
						default: begin
						end
					endcase
				end
			end
			OP_SCAN: begin
				depth_d = depth_nx;
				if (hit) begin
					fin  = 1'b1;
					pc_d = take ? PC_W'(k_q + 1'b1) : PC_W'(pc_q + 1'b1);
				end else if (k_fail) begin
					fin          = 1'b1;
					err_d        = 1'b1;
					res_d.status = ST_UNMATCHED;
				end else begin
					k_d        = k_next;
					code_raddr = k_next[CA_W-1:0];
				end
			end
			OP_CLEAR: begin
				tape_we    = 1'b1;
				tape_waddr = clr_q;
				clr_d      = TA_W'(clr_q + 1'b1);
			end
			OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_len_q <= '0;
			in_len_q   <= '0;
			in_pos_q   <= '0;
			dp_q       <= '0;
			pc_q       <= '0;
			err_q      <= 1'b0;
			clr_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			code_len_q <= code_len_d;
			in_len_q   <= in_len_d;
			in_pos_q   <= in_pos_d;
			dp_q       <= dp_d;
			pc_q       <= pc_d;
			err_q      <= err_d;
			clr_q      <= clr_d;
			done_q     <= fin;
		end
	end

	always_ff @(posedge clk) begin
		item_q  <= item_d;
		k_q     <= k_d;
		depth_q <= depth_d;
		fwd_q   <= fwd_d;
		cell_q  <= cell_d;
		if (fin) begin
			res_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

>>> test/bf_machine_core_test.sv
// Self-checking testbench for bf_machine_core: directed and random programs vs. a predictor.
module bf_machine_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bf_pkg::*;

	localparam int CYCLE_LIMIT  = 10_000_000;
	localparam int RANDOM_ITEMS = 1000;
	localparam int RANDOM_CLEARS = 12;

	logic    clk;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	logic    done;
	result_t result;

	bf_machine_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	// machine state as predicted
	logic [7:0] tape_mem [TAPE_CELLS];
	logic [7:0] code_mem [CODE_DEPTH];
	logic [7:0] in_mem [INPUT_DEPTH];
	int  code_len, in_len, in_pos, dptr, pc;
	bit  halted_err;

	result_t pending_results [$];
	status_t last_status;
	int burst_left;
	int items_sent, results_seen, mismatch_count, cycles;
	int bytes_emitted, bracket_errors, full_hits, clears;
	int random_clears;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_machine();
		foreach (tape_mem[i]) tape_mem[i] = 8'h00;
		foreach (code_mem[i]) code_mem[i] = 8'h00;
		foreach (in_mem[i]) in_mem[i] = 8'h00;
		code_len = 0;
		in_len = 0;
		in_pos = 0;
		dptr = 0;
		pc = 0;
		halted_err = 1'b0;
	endfunction

	// partner of the bracket at pos, scanning with a fresh depth count
	function automatic bit seek_partner(int pos, bit fwd, output int partner);
		int depth, k;
		depth = 1;
		k = pos;
		partner = 0;
		while (fwd ? (k + 1 < code_len) : (k > 0)) begin
			k = fwd ? k + 1 : k - 1;
			if (code_mem[k] == CH_OPEN)
				depth += fwd ? 1 : -1;
			else if (code_mem[k] == CH_CLOSE)
				depth += fwd ? -1 : 1;
			if (depth == 0) begin
				partner = k;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic result_t machine_step(item_t it);
		result_t r;
		logic [7:0] op;
		int nxt, partner;
		r = '0;
		r.status = ST_OK;
		case (it.action)
			ACT_CODE: begin
				if (code_len >= CODE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					code_mem[code_len] = it.byte_in;
					code_len++;
				end
			end
			ACT_INPUT: begin
				if (in_len >= INPUT_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					in_mem[in_len] = it.byte_in;
					in_len++;
				end
			end
			ACT_CLEAR: begin
				clear_machine();
				clears++;
			end
			default: begin
				if (halted_err) begin
					r.status = ST_UNMATCHED;
				end else if (pc >= code_len) begin
					r.status = ST_END;
				end else begin
					op = code_mem[pc];
					nxt = pc + 1;
					case (op)
						CH_RIGHT: dptr = (dptr == TAPE_CELLS - 1) ? 0 : dptr + 1;
						CH_LEFT:  dptr = (dptr == 0) ? TAPE_CELLS - 1 : dptr - 1;
						CH_PLUS:  tape_mem[dptr] = tape_mem[dptr] + 8'd1;
						CH_MINUS: tape_mem[dptr] = tape_mem[dptr] - 8'd1;
						CH_DOT: begin
							r.out_valid = 1'b1;
							r.out_byte = tape_mem[dptr];
						end
						CH_COMMA: begin
							if (in_pos < in_len) begin
								tape_mem[dptr] = in_mem[in_pos];
								in_pos++;
							end else begin
								tape_mem[dptr] = 8'h00;
							end
						end
						CH_OPEN: begin
							if (!seek_partner(pc, 1'b1, partner)) begin
								halted_err = 1'b1;
								r.status = ST_UNMATCHED;
								nxt = pc;
							end else if (tape_mem[dptr] == 8'h00) begin
								nxt = partner + 1;
							end
						end
						CH_CLOSE: begin
							if (!seek_partner(pc, 1'b0, partner)) begin
								halted_err = 1'b1;
								r.status = ST_UNMATCHED;
								nxt = pc;
							end else if (tape_mem[dptr] != 8'h00) begin
								nxt = partner + 1;
							end
						end
						default: ;
					endcase
					pc = nxt;
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (mismatch_count < 40)
			$display("mismatch on result %0d, %s: got %0d, expected %0d at %0t",
				results_seen, what, got, want, $time);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", int'(result), -1);
			end else begin
				want = pending_results.pop_front();
				if (result.out_valid !== want.out_valid)
					report_mismatch("out_valid", int'(result.out_valid),
						int'(want.out_valid));
				if (result.out_byte !== want.out_byte)
					report_mismatch("out_byte", int'(result.out_byte),
						int'(want.out_byte));
				if (result.status !== want.status)
					report_mismatch("status", int'(result.status), int'(want.status));
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_results.size());
			$display("bf_machine_core verification failed");
			$finish;
		end
	end

	// one transfer; the sender runs in bursts with idle gaps between them
	task automatic send_item(action_t act, logic [7:0] b);
		item_t it;
		result_t want;
		it.action = act;
		it.byte_in = b;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		burst_left--;
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		want = machine_step(it);
		pending_results.push_back(want);
		last_status = want.status;
		items_sent++;
		if (want.out_valid) bytes_emitted++;
		if (want.status == ST_UNMATCHED) bracket_errors++;
		if (want.status == ST_FULL) full_hits++;
	endtask

	task automatic load_code(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(ACT_CODE, s[i]);
	endtask

	task automatic run_to_stop(int max_steps);
		int n;
		n = 0;
		do begin
			send_item(ACT_EXEC, 8'($urandom));
			n++;
		end while (last_status == ST_OK && n < max_steps);
	endtask

	function automatic logic [7:0] plain_op();
		case ($urandom_range(0, 5))
			0: return CH_RIGHT;
			1: return CH_LEFT;
			2: return CH_PLUS;
			3: return CH_MINUS;
			4: return CH_DOT;
			default: return CH_COMMA;
		endcase
	endfunction

	function automatic logic [7:0] filler_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CH_OPEN || b == CH_CLOSE);
		return b;
	endfunction

	task automatic test_io_and_arith();
		send_item(ACT_EXEC, 8'h00);
		send_item(ACT_INPUT, 8'hFF);
		send_item(ACT_INPUT, 8'h00);
		load_code(",.,.,.+.--.");
		send_item(ACT_CODE, 8'h00);
		send_item(ACT_CODE, 8'hFF);
		load_code("a");
		run_to_stop(32);
		// input ran dry above; the position must not have moved
		send_item(ACT_INPUT, 8'h5A);
		load_code(",.");
		run_to_stop(8);
	endtask

	task automatic test_pointer_wrap();
		load_code("<+.>.<.");
		run_to_stop(16);
	endtask

	task automatic test_loops();
		load_code("[-][+]++[->+<]>.+[[-]]");
		run_to_stop(200);
	endtask

	task automatic test_unmatched();
		load_code("+[");
		run_to_stop(8);
		send_item(ACT_EXEC, 8'h00);
		send_item(ACT_CODE, CH_CLOSE);
		send_item(ACT_INPUT, 8'hA5);
		send_item(ACT_EXEC, 8'h00);
		send_item(ACT_CLEAR, 8'hFF);
		load_code("]");
		run_to_stop(4);
		send_item(ACT_CLEAR, 8'h00);
	endtask

	task automatic test_store_full();
		load_code(",[");
		for (int i = 0; i < CODE_DEPTH - 3; i++)
			send_item(ACT_CODE, filler_byte());
		send_item(ACT_CODE, CH_CLOSE);
		send_item(ACT_CODE, CH_PLUS);
		send_item(ACT_INPUT, 8'h00);
		for (int i = 1; i < INPUT_DEPTH; i++)
			send_item(ACT_INPUT, 8'($urandom));
		send_item(ACT_INPUT, 8'h77);
		run_to_stop(8);
	endtask

	task automatic send_program();
		int len, open, sel, written;
		len = $urandom_range(3, 24);
		open = 0;
		written = 0;
		for (int k = 0; k < len; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 8) begin
				send_item(ACT_INPUT, 8'($urandom));
			end else if (open > 0 && sel < 22) begin
				send_item(ACT_CODE, CH_CLOSE);
				open--;
				written++;
			end else if (sel < 35) begin
				send_item(ACT_CODE, CH_OPEN);
				open++;
				written++;
				if ($urandom_range(0, 9) < 7) begin
					send_item(ACT_CODE, CH_MINUS);
					written++;
				end
			end else if (sel < 40) begin
				send_item(ACT_CODE, filler_byte());
				written++;
			end else begin
				send_item(ACT_CODE, plain_op());
				written++;
			end
		end
		while (open > 0) begin
			send_item(ACT_CODE, CH_CLOSE);
			open--;
			written++;
		end
		repeat (2 * written + $urandom_range(0, 8))
			send_item(ACT_EXEC, 8'($urandom));
	endtask

	task automatic noise_burst();
		logic [7:0] b;
		repeat ($urandom_range(4, 12)) begin
			case ($urandom_range(0, 3))
				0: b = CH_OPEN;
				1: b = CH_CLOSE;
				2: b = plain_op();
				default: b = 8'($urandom);
			endcase
			send_item(action_t'($urandom_range(0, 2)), b);
		end
	endtask

	task automatic test_random_programs();
		int first;
		bit stuck;
		first = items_sent;
		while (items_sent - first < RANDOM_ITEMS) begin
			stuck = !halted_err && pc < code_len && $urandom_range(0, 3) == 0;
			if ((halted_err || code_len > 300 || stuck) && random_clears < RANDOM_CLEARS) begin
				send_item(ACT_CLEAR, 8'($urandom));
				random_clears++;
			end
			if ($urandom_range(0, 9) == 0)
				noise_burst();
			else
				send_program();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		clear_machine();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_io_and_arith();
		test_pointer_wrap();
		test_loops();
		test_unmatched();
		test_store_full();
		test_random_programs();

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);

		$display("covered %0d transfers, %0d results checked, %0d bytes emitted",
			items_sent, results_seen, bytes_emitted);
		$display("%0d bracket errors, %0d store-full rejections, %0d machine clears",
			bracket_errors, full_hits, clears);
		if (mismatch_count == 0) begin
			$display("bf_machine_core verification clean");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("bf_machine_core verification failed");
		end
		$finish;
	end

endmodule
